@@ rtl/packed_10bit_channel_demux_macros.svh @@
// Assertion macros shared by the demux checker.
`ifndef PACKED_10BIT_CHANNEL_DEMUX_MACROS_SVH
`define PACKED_10BIT_CHANNEL_DEMUX_MACROS_SVH

// Clocked assertion, disabled while reset is held low.
`define P10CD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define P10CD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/p10cd_pkg.sv @@
// Package: shared types and constants of the packed 10-bit channel demux.
package p10cd_pkg;

    localparam int NUM_CH      = 6;
    localparam int CH_W        = 3;
    localparam int BYTE_W      = 8;
    localparam int SAMPLE_W    = 10;
    localparam int GAIN_W      = 7;
    localparam int START_W     = 11;
    localparam int HDR_W       = 8;
    localparam int COLUMN_W    = 8;
    localparam int LINE_OUT_W  = 19;
    localparam int PIXEL_W     = 16;
    localparam int PROD_W      = SAMPLE_W + GAIN_W;
    localparam int DIFF_W      = START_W + 1;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 11;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    localparam logic [2:0] PHASE_LAST = 3'd4;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_HEADER_SKIP = 3'd0;
    localparam t_cfg_idx CFG_GAIN        = 3'd1;
    localparam t_cfg_idx CFG_START_CH0   = 3'd2;

    localparam logic [HDR_W-1:0]  RST_HEADER_SKIP = 8'd100;
    localparam logic [GAIN_W-1:0] RST_GAIN        = 7'd60;

    typedef logic [START_W-1:0] t_start_arr [NUM_CH];

    localparam t_start_arr RST_START = '{11'd37, 11'd229, 11'd420,
                                         11'd612, 11'd804, 11'd997};

    typedef struct packed {
        logic [HDR_W-1:0]                 header_skip;
        logic [GAIN_W-1:0]                gain;
        logic [NUM_CH-1:0][START_W-1:0]   start;
    } t_cfg;

endpackage

@@ rtl/p10cd_in_if.sv @@
// Interfaces: byte input channel and sample result channel.
interface p10cd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_first;

    modport source (output valid, output data_byte, output frame_first, input ready);
    modport sink   (input valid, input data_byte, input frame_first, output ready);
endinterface

interface p10cd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  channel;
    logic [7:0]  column;
    logic [18:0] line_index;
    logic [15:0] pixel_value;

    modport source (output valid, output channel, output column, output line_index,
                    output pixel_value, input ready);
    modport sink   (input valid, input channel, input column, input line_index,
                    input pixel_value, output ready);
endinterface

@@ rtl/p10cd_front.sv @@
// Front end: frame tracking, header skip and 10-bit unpacking.
module p10cd_front #(
    parameter int SAMPLES_PER_LINE = 1108,
    parameter int LINE_COUNT_MAX   = 524288,
    localparam int SIW = $clog2(SAMPLES_PER_LINE + 1),
    localparam int IW  = $clog2(SAMPLES_PER_LINE),
    localparam int LCW = $clog2(LINE_COUNT_MAX)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  p10cd_pkg::t_cfg                  i_cfg,
    input  logic                             i_accept,
    input  logic [p10cd_pkg::BYTE_W-1:0]     i_data_byte,
    input  logic                             i_frame_first,
    output logic                             o_push,
    output logic [p10cd_pkg::SAMPLE_W-1:0]   o_sample,
    output logic [IW-1:0]                    o_index,
    output logic [LCW-1:0]                   o_line
);

    localparam logic [LCW-1:0] LC_LAST = LCW'(LINE_COUNT_MAX - 1);
    localparam logic [SIW-1:0] SPL     = SIW'(SAMPLES_PER_LINE);
    localparam logic [2:0] PHASE_LAST_L = p10cd_pkg::PHASE_LAST;

    logic                          r_frame_seen, n_frame_seen;
    logic [p10cd_pkg::HDR_W-1:0]   r_byte_pos,   n_byte_pos;
    logic [2:0]                    r_phase,      n_phase;
    logic [p10cd_pkg::BYTE_W-1:0]  r_held,       n_held;
    logic [SIW-1:0]                r_sample_idx, n_sample_idx;
    logic [LCW-1:0]                r_line,       n_line;

    // Values after the frame-start restart, before this byte is consumed
    logic                          fs;
    logic [p10cd_pkg::HDR_W-1:0]   bp;
    logic [2:0]                    ph;
    logic [p10cd_pkg::BYTE_W-1:0]  hd;
    logic [SIW-1:0]                si;
    logic [LCW-1:0]                ln;
    logic                          got;
    logic [p10cd_pkg::SAMPLE_W-1:0] smp;

    always_comb begin
        fs = r_frame_seen;
        bp = r_byte_pos;
        ph = r_phase;
        hd = r_held;
        si = r_sample_idx;
        ln = r_line;
        if (i_frame_first) begin
            if (r_frame_seen) begin
                ln = (r_line == LC_LAST) ? '0 : r_line + 1'b1;
            end
            fs = 1'b1;
            bp = '0;
            ph = '0;
            hd = '0;
            si = '0;
        end
    end

    // Big-endian 10-bit unpack: four samples over bytes 1..4 of each group
    always_comb begin
        got = 1'b1;
        case (ph)
            3'd1:    smp = {hd, i_data_byte[7:6]};
            3'd2:    smp = {hd[5:0], i_data_byte[7:4]};
            3'd3:    smp = {hd[3:0], i_data_byte[7:2]};
            3'd4:    smp = {hd[1:0], i_data_byte};
            default: begin
                smp = '0;
                got = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_frame_seen = r_frame_seen;
        n_byte_pos   = r_byte_pos;
        n_phase      = r_phase;
        n_held       = r_held;
        n_sample_idx = r_sample_idx;
        n_line       = r_line;
        o_push       = 1'b0;
        if (i_accept) begin
            n_frame_seen = fs;
            n_byte_pos   = bp;
            n_phase      = ph;
            n_held       = hd;
            n_sample_idx = si;
            n_line       = ln;
            if (fs) begin
                if (bp < i_cfg.header_skip) begin
                    n_byte_pos = bp + 1'b1;
                end else if (si < SPL) begin
                    n_held  = i_data_byte;
                    n_phase = (ph >= PHASE_LAST_L) ? '0 : ph + 1'b1;
                    if (got) begin
                        o_push       = 1'b1;
                        n_sample_idx = si + 1'b1;
                    end
                end
            end
        end
    end

    assign o_sample = smp;
    assign o_index  = si[IW-1:0];
    assign o_line   = ln;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_seen <= 1'b0;
            r_byte_pos   <= '0;
            r_phase      <= '0;
            r_held       <= '0;
            r_sample_idx <= '0;
            r_line       <= '0;
        end else begin
            r_frame_seen <= n_frame_seen;
            r_byte_pos   <= n_byte_pos;
            r_phase      <= n_phase;
            r_held       <= n_held;
            r_sample_idx <= n_sample_idx;
            r_line       <= n_line;
        end
    end

endmodule

@@ rtl/p10cd_queue.sv @@
// Short FIFO between the unpacking front end and the window back end.
module p10cd_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = p10cd_pkg::QUEUE_PTR_W;
    localparam int CW = p10cd_pkg::QUEUE_CNT_W;
    localparam logic [CW-1:0] DEPTH = CW'(p10cd_pkg::QUEUE_DEPTH);

    logic [WIDTH-1:0] r_mem [p10cd_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == DEPTH);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr + PW'(do_push);
        n_rd_ptr = r_rd_ptr + PW'(do_pop);
        n_count  = r_count + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

@@ rtl/p10cd_back.sv @@
// Back end: channel window match, gain multiply and output register.
module p10cd_back #(
    parameter int SAMPLES_PER_LINE = 1108,
    parameter int CHANNEL_WIDTH    = 184,
    parameter int LINE_COUNT_MAX   = 524288,
    localparam int IW  = $clog2(SAMPLES_PER_LINE),
    localparam int LCW = $clog2(LINE_COUNT_MAX)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  p10cd_pkg::t_cfg                    i_cfg,
    input  logic                               i_head_valid,
    input  logic [p10cd_pkg::SAMPLE_W-1:0]     i_sample,
    input  logic [IW-1:0]                      i_index,
    input  logic [LCW-1:0]                     i_line,
    output logic                               o_pop,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [p10cd_pkg::CH_W-1:0]         o_channel,
    output logic [p10cd_pkg::COLUMN_W-1:0]     o_column,
    output logic [p10cd_pkg::LINE_OUT_W-1:0]   o_line_index,
    output logic [p10cd_pkg::PIXEL_W-1:0]      o_pixel_value
);

    localparam int DW = p10cd_pkg::DIFF_W;
    localparam logic [DW-1:0] CW_L = DW'(CHANNEL_WIDTH);

    logic [DW-1:0]                     idx_ext;
    logic [DW-1:0]                     diff [p10cd_pkg::NUM_CH];
    logic                              hit;
    logic [p10cd_pkg::CH_W-1:0]        hit_ch;
    logic [DW-1:0]                     hit_diff;
    logic [p10cd_pkg::PROD_W-1:0]      prod;
    logic [p10cd_pkg::PIXEL_W-1:0]     pix;
    logic                              load;

    logic                              r_valid, n_valid;
    logic [p10cd_pkg::CH_W-1:0]        r_channel;
    logic [p10cd_pkg::COLUMN_W-1:0]    r_column;
    logic [p10cd_pkg::LINE_OUT_W-1:0]  r_line_index;
    logic [p10cd_pkg::PIXEL_W-1:0]     r_pixel;

    assign idx_ext = DW'(i_index);

    // Scan from the top channel down so the lowest matching channel wins
    always_comb begin
        hit      = 1'b0;
        hit_ch   = '0;
        hit_diff = '0;
        for (int c = p10cd_pkg::NUM_CH - 1; c >= 0; c--) begin
            diff[c] = idx_ext - {1'b0, i_cfg.start[c]};
            if ((idx_ext >= {1'b0, i_cfg.start[c]}) && (diff[c] < CW_L)) begin
                hit      = 1'b1;
                hit_ch   = p10cd_pkg::CH_W'(c);
                hit_diff = diff[c];
            end
        end
    end

    assign prod = p10cd_pkg::PROD_W'(i_sample) * p10cd_pkg::PROD_W'(i_cfg.gain);
    assign pix  = (|prod[p10cd_pkg::PROD_W-1:p10cd_pkg::PIXEL_W]) ? '1
                                                               : prod[p10cd_pkg::PIXEL_W-1:0];

    // Output stage takes the head whenever it is empty or being drained;
    // heads that fall in no window are popped and dropped.
    assign load  = !r_valid || i_ready;
    assign o_pop = i_head_valid && load;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = i_head_valid && hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_channel    <= hit_ch;
            r_column     <= hit_diff[p10cd_pkg::COLUMN_W-1:0];
            r_line_index <= p10cd_pkg::LINE_OUT_W'(i_line);
            r_pixel      <= pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_valid       = r_valid;
    assign o_channel     = r_channel;
    assign o_column      = r_column;
    assign o_line_index  = r_line_index;
    assign o_pixel_value = r_pixel;

endmodule

@@ rtl/packed_10bit_channel_demux.sv @@
// Top level: packed 10-bit channel demux with configuration registers.
//
// Usage:
//   i_in  : byte stream, one frame byte per transaction; frame_first marks
//           the first byte of each scan line. Bytes before the first marked
//           byte are dropped.
//   o_out : one transaction per sample that lands in a channel window,
//           carrying channel, column in the window, line number and
//           sample * gain (saturated to 16 bits).
//   cfg   : i_cfg_wr_en/i_cfg_index/i_cfg_wdata, written only while idle.
// Throughput: one byte per cycle while the queue has room; four of every five payload
//   bytes produce a sample candidate.
// Path: a sample-completing byte is unpacked combinationally into the queue,
//   then passes from the queue head through the window/gain output register
//   onto o_out.
// Stall: a 4-entry queue decouples the front from the output register.
//   While o_out is stalled the queue fills, then i_in.ready drops.
// Reset: synchronous, active low; clears counters, line number, queue
//   and output valid, and restores register defaults.
module packed_10bit_channel_demux #(
    parameter int SAMPLES_PER_LINE = 1108,
    parameter int CHANNEL_WIDTH    = 184,
    parameter int LINE_COUNT_MAX   = 524288
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    p10cd_in_if.sink                            i_in,
    p10cd_out_if.source                         o_out,
    input  logic                                i_cfg_wr_en,
    input  logic [p10cd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [p10cd_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    localparam int IW  = $clog2(SAMPLES_PER_LINE);
    localparam int LCW = $clog2(LINE_COUNT_MAX);
    localparam int QW  = LCW + IW + p10cd_pkg::SAMPLE_W;

    p10cd_pkg::t_cfg                  r_cfg, n_cfg;
    p10cd_pkg::t_cfg_idx              start_sel;

    logic                             in_accept;
    logic                             push;
    logic [p10cd_pkg::SAMPLE_W-1:0]   f_sample;
    logic [IW-1:0]                    f_index;
    logic [LCW-1:0]                   f_line;
    logic                             q_full;
    logic                             q_valid;
    logic                             q_pop;
    logic [QW-1:0]                    q_data;

    // Configuration registers
    assign start_sel = i_cfg_index - p10cd_pkg::CFG_START_CH0;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                p10cd_pkg::CFG_HEADER_SKIP: n_cfg.header_skip = i_cfg_wdata[p10cd_pkg::HDR_W-1:0];
                p10cd_pkg::CFG_GAIN:        n_cfg.gain = i_cfg_wdata[p10cd_pkg::GAIN_W-1:0];
                default:                    n_cfg.start[start_sel] = i_cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_skip <= p10cd_pkg::RST_HEADER_SKIP;
            r_cfg.gain        <= p10cd_pkg::RST_GAIN;
            for (int c = 0; c < p10cd_pkg::NUM_CH; c++) begin
                r_cfg.start[c] <= p10cd_pkg::RST_START[c];
            end
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Input handshake: take a byte whenever the queue has room
    assign i_in.ready = !q_full;
    assign in_accept  = i_in.valid && !q_full;

    p10cd_front #(
        .SAMPLES_PER_LINE (SAMPLES_PER_LINE),
        .LINE_COUNT_MAX   (LINE_COUNT_MAX)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_accept      (in_accept),
        .i_data_byte   (i_in.data_byte),
        .i_frame_first (i_in.frame_first),
        .o_push        (push),
        .o_sample      (f_sample),
        .o_index       (f_index),
        .o_line        (f_line)
    );

    p10cd_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_line, f_index, f_sample}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    p10cd_back #(
        .SAMPLES_PER_LINE (SAMPLES_PER_LINE),
        .CHANNEL_WIDTH    (CHANNEL_WIDTH),
        .LINE_COUNT_MAX   (LINE_COUNT_MAX)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_head_valid  (q_valid),
        .i_sample      (q_data[p10cd_pkg::SAMPLE_W-1:0]),
        .i_index       (q_data[IW+p10cd_pkg::SAMPLE_W-1:p10cd_pkg::SAMPLE_W]),
        .i_line        (q_data[QW-1:IW+p10cd_pkg::SAMPLE_W]),
        .o_pop         (q_pop),
        .o_valid       (o_out.valid),
        .i_ready       (o_out.ready),
        .o_channel     (o_out.channel),
        .o_column      (o_out.column),
        .o_line_index  (o_out.line_index),
        .o_pixel_value (o_out.pixel_value)
    );

endmodule

@@ rtl/p10cd_checker.sv @@
// Port-level checker for the demux, bound to the top level.
`include "packed_10bit_channel_demux_macros.svh"

module p10cd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_out_channel,
    input logic [7:0]  i_out_column,
    input logic [18:0] i_out_line_index,
    input logic [15:0] i_out_pixel_value
);

    localparam logic [2:0] CH_MAX = 3'(p10cd_pkg::NUM_CH - 1);

    `P10CD_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result transaction dropped while stalled")
    `P10CD_ASSERT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(i_out_channel) && $stable(i_out_column) && $stable(i_out_line_index) && $stable(i_out_pixel_value), "result payload changed while stalled")
    `P10CD_ASSERT(a_chan_range, i_clk, i_rst_n, i_out_valid |-> i_out_channel <= CH_MAX, "channel out of range")
    `P10CD_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !i_out_valid, "result valid right after reset")

endmodule

bind packed_10bit_channel_demux p10cd_checker u_p10cd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_channel     (o_out.channel),
    .i_out_column      (o_out.column),
    .i_out_line_index  (o_out.line_index),
    .i_out_pixel_value (o_out.pixel_value)
);

@@ dv/packed_10bit_channel_demux_tb.sv @@
// Testbench for the packed 10-bit channel demux: directed and random frames vs a predictor.
module packed_10bit_channel_demux_tb;

    localparam int LINE_SAMPLES = 1108;
    localparam int WIN_WIDTH    = 184;
    localparam int LINE_WRAP    = 524288;

    typedef struct {
        logic [2:0]  channel;
        logic [7:0]  column;
        logic [18:0] line_index;
        logic [15:0] pixel_value;
    } t_pixel_result;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             cfg_wr_en;
    p10cd_pkg::t_cfg_idx              cfg_index;
    logic [p10cd_pkg::CFG_DATA_W-1:0] cfg_wdata;

    p10cd_in_if  in_if ();
    p10cd_out_if out_if ();

    packed_10bit_channel_demux #(
        .SAMPLES_PER_LINE (LINE_SAMPLES),
        .CHANNEL_WIDTH    (WIN_WIDTH),
        .LINE_COUNT_MAX   (LINE_WRAP)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor copy of the register file
    int hdr_len;
    int gain_val;
    int win_start [p10cd_pkg::NUM_CH];

    // Predictor copy of the unpack state
    int         hdr_count;
    int         grp_phase;
    logic [7:0] prev_byte;
    int         line_pos;
    int         line_num;
    bit         in_frame;

    t_pixel_result expected_pixels[$];
    int            mismatch_count = 0;

    // Idle control for the sender and the receiver process
    bit tx_idle = 1'b0;
    bit rx_idle = 1'b0;
    int rx_hold = 0;
    int rx_stall = 0;

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap(bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Byte-level model: header skip, 5-byte/4-sample unpack, window lookup.
    function automatic void unpack_and_window(logic [7:0] b, logic first);
        logic [9:0]    smp;
        bit            got;
        bit            placed;
        int            idx;
        int            prod;
        t_pixel_result px;
        if (first) begin
            if (in_frame)
                line_num = (line_num == LINE_WRAP - 1) ? 0 : line_num + 1;
            in_frame  = 1'b1;
            hdr_count = 0;
            grp_phase = 0;
            prev_byte = 8'd0;
            line_pos  = 0;
        end
        if (!in_frame)
            return;
        if (hdr_count < hdr_len) begin
            hdr_count++;
            return;
        end
        if (line_pos >= LINE_SAMPLES)
            return;
        got = 1'b1;
        smp = '0;
        case (grp_phase)
            1: smp = {prev_byte, b[7:6]};
            2: smp = {prev_byte[5:0], b[7:4]};
            3: smp = {prev_byte[3:0], b[7:2]};
            4: smp = {prev_byte[1:0], b};
            default: got = 1'b0;
        endcase
        prev_byte = b;
        grp_phase = (grp_phase >= 4) ? 0 : grp_phase + 1;
        if (!got)
            return;
        idx = line_pos;
        line_pos++;
        prod = smp * gain_val;
        if (prod > 65535)
            prod = 65535;
        // lowest channel wins on overlap
        placed = 1'b0;
        for (int c = 0; c < p10cd_pkg::NUM_CH; c++) begin
            if (!placed && idx >= win_start[c] && idx - win_start[c] < WIN_WIDTH) begin
                px.channel     = 3'(c);
                px.column      = 8'(idx - win_start[c]);
                px.line_index  = 19'(line_num);
                px.pixel_value = 16'(prod);
                expected_pixels.push_back(px);
                placed = 1'b1;
            end
        end
    endfunction

    task automatic cfg_write(p10cd_pkg::t_cfg_idx idx, logic [p10cd_pkg::CFG_DATA_W-1:0] v);
        @(negedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            p10cd_pkg::CFG_HEADER_SKIP: hdr_len = v[p10cd_pkg::HDR_W-1:0];
            p10cd_pkg::CFG_GAIN:        gain_val = v[p10cd_pkg::GAIN_W-1:0];
            default:                    win_start[idx - p10cd_pkg::CFG_START_CH0] = v;
        endcase
    endtask

    task automatic program_windows(int s0, int s1, int s2, int s3, int s4, int s5);
        int s [p10cd_pkg::NUM_CH];
        s = '{s0, s1, s2, s3, s4, s5};
        for (int c = 0; c < p10cd_pkg::NUM_CH; c++)
            cfg_write(p10cd_pkg::CFG_START_CH0 + p10cd_pkg::t_cfg_idx'(c),
                      p10cd_pkg::CFG_DATA_W'(s[c]));
    endtask

    // One byte transaction; valid stays high into the next call unless a gap is drawn.
    task automatic send_byte(logic [7:0] b, logic first);
        int gap;
        gap = pick_gap(tx_idle);
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.data_byte   <= b;
        in_if.frame_first <= first;
        do @(posedge i_clk); while (!in_if.ready);
        unpack_and_window(b, first);
    endtask

    task automatic send_random_frame(int len, bit allow_restart);
        logic first;
        for (int i = 0; i < len; i++) begin
            first = (i == 0) || (allow_restart && $urandom_range(0, 59) == 0);
            send_byte(8'($urandom_range(0, 255)), first);
        end
    endtask

    // Stop the sender, let every expected transaction arrive, then allow the pipe to settle.
    task automatic drain;
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Receiver: random stalls plus an optional long hold-off counted here.
    initial begin
        int g;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                out_if.ready <= 1'b0;
                rx_hold--;
            end else if (rx_stall > 0) begin
                out_if.ready <= 1'b0;
                rx_stall--;
            end else begin
                g = pick_gap(rx_idle);
                if (g > 0) begin
                    out_if.ready <= 1'b0;
                    rx_stall = g - 1;
                end else begin
                    out_if.ready <= 1'b1;
                end
            end
        end
    end

    // Result checker: compare each output transaction with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_pixel_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected result ch=%0d col=%0d",
                                          out_if.channel, out_if.column));
            end else begin
                want = expected_pixels.pop_front();
                if (out_if.channel !== want.channel)
                    report_mismatch($sformatf("channel got %0d want %0d",
                                              out_if.channel, want.channel));
                if (out_if.column !== want.column)
                    report_mismatch($sformatf("column got %0d want %0d",
                                              out_if.column, want.column));
                if (out_if.line_index !== want.line_index)
                    report_mismatch($sformatf("line_index got %0d want %0d",
                                              out_if.line_index, want.line_index));
                if (out_if.pixel_value !== want.pixel_value)
                    report_mismatch($sformatf("pixel_value got %0d want %0d",
                                              out_if.pixel_value, want.pixel_value));
            end
        end
    end

    // Reset register values: stray bytes before any frame, then a frame
    // long enough to pass the default header and reach channel 0.
    task automatic test_reset_defaults;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        repeat (3) send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_random_frame(150, 1'b0);
        drain();
    endtask

    // Full-scale and zero samples, saturation, overlap, far windows,
    // and a new frame landing in the middle of a 5-byte group.
    task automatic test_field_extremes;
        logic [7:0] pattern [15];
        cfg_write(p10cd_pkg::CFG_HEADER_SKIP, 11'h700);   // upper bits ignored, header = 0
        cfg_write(p10cd_pkg::CFG_GAIN, 11'h07F);
        program_windows(2, 0, 2047, 1107, 1200, 1500);
        pattern = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                    8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                    8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA};
        for (int i = 0; i < 15; i++)
            send_byte(pattern[i], i == 0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h81, 1'b1);
        send_byte(8'h7E, 1'b0);
        send_byte(8'hE7, 1'b0);
        send_byte(8'h18, 1'b0);
        send_byte(8'hFF, 1'b0);
        drain();
    endtask

    task automatic test_gain_extremes;
        cfg_write(p10cd_pkg::CFG_GAIN, 11'h780);          // gain = 0
        repeat (5) send_byte(8'hFF, 1'b0);
        drain();
        cfg_write(p10cd_pkg::CFG_GAIN, 11'h040);          // top of range, no saturation
        send_byte(8'hFF, 1'b1);
        repeat (4) send_byte(8'hFF, 1'b0);
        drain();
    endtask

    // Receiver holds off long enough for the internal queue to fill
    // and push back on the byte input.
    task automatic test_backpressure;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        cfg_write(p10cd_pkg::CFG_HEADER_SKIP, 11'd0);
        program_windows(0, 300, 600, 900, 1000, 1100);
        rx_hold = 120;
        send_random_frame(80, 1'b0);
        drain();
    endtask

    task automatic random_config;
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            cfg_write(p10cd_pkg::CFG_HEADER_SKIP,
                      p10cd_pkg::CFG_DATA_W'($urandom_range(0, 6)));
        else if (r < 90)
            cfg_write(p10cd_pkg::CFG_HEADER_SKIP,
                      p10cd_pkg::CFG_DATA_W'($urandom_range(0, 40)));
        else
            // junk in the bits above the register width
            cfg_write(p10cd_pkg::CFG_HEADER_SKIP,
                      p10cd_pkg::CFG_DATA_W'(($urandom_range(0, 7) << 8) |
                                             $urandom_range(0, 60)));
        cfg_write(p10cd_pkg::CFG_GAIN, p10cd_pkg::CFG_DATA_W'($urandom_range(0, 2047)));
        for (int c = 0; c < p10cd_pkg::NUM_CH; c++) begin
            if ($urandom_range(0, 3) != 0)
                cfg_write(p10cd_pkg::CFG_START_CH0 + p10cd_pkg::t_cfg_idx'(c),
                          p10cd_pkg::CFG_DATA_W'($urandom_range(0, 40)));
            else
                cfg_write(p10cd_pkg::CFG_START_CH0 + p10cd_pkg::t_cfg_idx'(c),
                          p10cd_pkg::CFG_DATA_W'($urandom_range(0, 2047)));
        end
    endtask

    // Random register settings, each followed by a few frames of random bytes;
    // a stray frame restart now and then.
    task automatic test_random_frames;
        int sent;
        int len;
        sent = 0;
        while (sent < 230) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            random_config();
            repeat ($urandom_range(2, 5)) begin
                if (sent < 230) begin
                    len = hdr_len + $urandom_range(3, 50);
                    send_random_frame(len, 1'b1);
                    sent += len;
                end
            end
            drain();
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_index         = p10cd_pkg::CFG_HEADER_SKIP;
        cfg_wdata         = '0;
        in_if.valid       = 1'b0;
        in_if.data_byte   = 8'd0;
        in_if.frame_first = 1'b0;

        hdr_len  = p10cd_pkg::RST_HEADER_SKIP;
        gain_val = p10cd_pkg::RST_GAIN;
        for (int c = 0; c < p10cd_pkg::NUM_CH; c++)
            win_start[c] = p10cd_pkg::RST_START[c];
        hdr_count = 0;
        grp_phase = 0;
        prev_byte = 8'd0;
        line_pos  = 0;
        line_num  = 0;
        in_frame  = 1'b0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_field_extremes();
        test_gain_extremes();
        test_backpressure();
        test_random_frames();

        if (mismatch_count == 0 && expected_pixels.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #50000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
